// ----- hw/rtl/hdlf_pkg.sv -----
// Shared types, character constants and helper functions for the hex dump formatter.
`default_nettype none

package hdlf_pkg;

  // Default number of bytes shown on one dump line
  localparam int BytesPerLineDefault = 16;

  // ASCII codes used in the dump text
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_LOW   = 8'h20;
  localparam logic [7:0] CH_HIGH  = 8'h7e;

  // Source of the character loaded into the output register
  typedef enum logic [2:0] {
    SEL_OFS   = 3'd0,
    SEL_COLON = 3'd1,
    SEL_SPACE = 3'd2,
    SEL_HI    = 3'd3,
    SEL_LO    = 3'd4,
    SEL_ASCII = 3'd5,
    SEL_NL    = 3'd6
  } sel_t;

  // Operation on the shared step counter
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2,
    CNT_PAD  = 2'd3
  } cnt_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    accept;
    logic    emit;
    sel_t    sel;
    logic    last;
    cnt_op_t cnt_op;
    logic    ph_clr;
    logic    ph_inc;
    logic    pos_adv;
    logic    line_close;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic pos_zero;
    logic pos_odd;
    logic close;
    logic full;
    logic dig_last;
    logic pad_slot_end;
    logic pad_last_slot;
    logic asc_last;
  } sts_t;

  // Lower-case hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

  // Byte as shown in the ASCII column
  function automatic logic [7:0] printable(input logic [7:0] b);
    logic [7:0] c;
    if (b >= CH_LOW && b <= CH_HIGH) begin
      c = b;
    end else begin
      c = CH_DOT;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hdlf_ctrl.sv -----
// Controller state machine that sequences the characters of each input byte.
`default_nettype none

module hdlf_ctrl
  import hdlf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_OFS   = 11'b000_0000_0010,
    ST_COLON = 11'b000_0000_0100,
    ST_SP1   = 11'b000_0000_1000,
    ST_HI    = 11'b000_0001_0000,
    ST_LO    = 11'b000_0010_0000,
    ST_GRP   = 11'b000_0100_0000,
    ST_PAD   = 11'b000_1000_0000,
    ST_SEP   = 11'b001_0000_0000,
    ST_ASC   = 11'b010_0000_0000,
    ST_NL    = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   go;

  assign go       = sts.out_free;
  assign in_ready = (state == ST_IDLE);

  // Advance the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.sel        = SEL_SPACE;
    cmd.cnt_op     = CNT_HOLD;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        cmd.cnt_op = CNT_CLR;
        if (in_valid) begin
          state_next = sts.pos_zero ? ST_OFS : ST_HI;
        end
      end
      ST_OFS: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_OFS;
        if (go) begin
          if (sts.dig_last) begin
            state_next = ST_COLON;
          end else begin
            cmd.cnt_op = CNT_INC;
          end
        end
      end
      ST_COLON: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_COLON;
        if (go) begin
          state_next = ST_SP1;
        end
      end
      ST_SP1: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_SPACE;
        if (go) begin
          state_next = ST_HI;
        end
      end
      ST_HI: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_HI;
        if (go) begin
          state_next = ST_LO;
        end
      end
      ST_LO: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_LO;
        cmd.last = !sts.pos_odd && !sts.close;
        if (go) begin
          if (sts.pos_odd) begin
            state_next = ST_GRP;
          end else if (sts.full) begin
            state_next = ST_SEP;
          end else if (sts.close) begin
            state_next = ST_PAD;
            cmd.cnt_op = CNT_PAD;
            cmd.ph_clr = 1'b1;
          end else begin
            state_next  = ST_IDLE;
            cmd.pos_adv = 1'b1;
          end
        end
      end
      ST_GRP: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_SPACE;
        cmd.last = !sts.close;
        if (go) begin
          if (sts.full) begin
            state_next = ST_SEP;
          end else if (sts.close) begin
            state_next = ST_PAD;
            cmd.cnt_op = CNT_PAD;
            cmd.ph_clr = 1'b1;
          end else begin
            state_next  = ST_IDLE;
            cmd.pos_adv = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_SPACE;
        if (go) begin
          if (sts.pad_slot_end) begin
            cmd.ph_clr = 1'b1;
            if (sts.pad_last_slot) begin
              state_next = ST_SEP;
            end else begin
              cmd.cnt_op = CNT_INC;
            end
          end else begin
            cmd.ph_inc = 1'b1;
          end
        end
      end
      ST_SEP: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_SPACE;
        if (go) begin
          state_next = ST_ASC;
          cmd.cnt_op = CNT_CLR;
        end
      end
      ST_ASC: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_ASCII;
        if (go) begin
          if (sts.asc_last) begin
            state_next = ST_NL;
          end else begin
            cmd.cnt_op = CNT_INC;
          end
        end
      end
      ST_NL: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_NL;
        cmd.last = 1'b1;
        if (go) begin
          state_next     = ST_IDLE;
          cmd.line_close = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hdlf_dp.sv -----
// Datapath: input byte, line offset and position, ASCII column, counters, output register.
`default_nettype none

module hdlf_dp
  import hdlf_pkg::*;
#(
  parameter int BYTES_PER_LINE = BytesPerLineDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eod,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);

  localparam int PosW = $clog2(BYTES_PER_LINE);
  localparam int CntW = (PosW > 3) ? PosW : 3;

  logic [7:0]      byte_r;
  logic            eod_r;
  logic [31:0]     offset;
  logic [PosW-1:0] pos;
  logic [7:0]      ascii_col [BYTES_PER_LINE];
  logic [CntW-1:0] cnt;
  logic [1:0]      ph;
  logic [2:0]      dig_sel;
  logic [7:0]      char_next;
  logic            load;

  // Latch the accepted byte and record its printable form
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r         <= in_byte;
      eod_r          <= in_eod;
      ascii_col[pos] <= printable(in_byte);
    end
  end

  // Hold line offset and position within the line
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      pos    <= '0;
    end else if (cmd.line_close) begin
      offset <= offset + 32'(BYTES_PER_LINE);
      pos    <= '0;
    end else if (cmd.pos_adv) begin
      pos <= pos + PosW'(1);
    end
  end

  // Step counter for offset digits, pad slots and ASCII entries
  always_ff @(posedge clk) begin
    case (cmd.cnt_op)
      CNT_CLR: cnt <= '0;
      CNT_INC: cnt <= cnt + CntW'(1);
      CNT_PAD: cnt <= CntW'(pos) + CntW'(1);
      default: cnt <= cnt;
    endcase
    if (cmd.ph_clr) begin
      ph <= '0;
    end else if (cmd.ph_inc) begin
      ph <= ph + 2'd1;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.out_free      = !out_valid || out_ready;
    sts.pos_zero      = (pos == '0);
    sts.pos_odd       = pos[0];
    sts.full          = (pos == PosW'(BYTES_PER_LINE - 1));
    sts.close         = eod_r || sts.full;
    sts.dig_last      = (cnt == CntW'(7));
    sts.pad_slot_end  = (ph == 2'd2) || (ph == 2'd1 && !cnt[0]);
    sts.pad_last_slot = (cnt == CntW'(BYTES_PER_LINE - 1));
    sts.asc_last      = (cnt == CntW'(pos));
  end

  // Select the next character
  assign dig_sel = 3'd7 - cnt[2:0];
  always_comb begin
    case (cmd.sel)
      SEL_OFS:   char_next = hex_char(offset[{dig_sel, 2'b00} +: 4]);
      SEL_COLON: char_next = CH_COLON;
      SEL_SPACE: char_next = CH_SPACE;
      SEL_HI:    char_next = hex_char(byte_r[7:4]);
      SEL_LO:    char_next = hex_char(byte_r[3:0]);
      SEL_ASCII: char_next = ascii_col[cnt[PosW-1:0]];
      SEL_NL:    char_next = CH_NL;
      default:   char_next = CH_SPACE;
    endcase
  end

  // Output register: load when free, drop valid after the transfer
  assign load = cmd.emit && sts.out_free;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      out_last <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hex_dump_line_formatter.sv -----
// Top level of the hex dump line formatter: controller, datapath and checks.
// The first character of a byte is registered in the output register after the controller leaves the idle state.
// Throughput: one character per cycle unless the output stalls; a new byte is taken only in the idle state,
// after the previous byte's 2 to 53 characters, paced by the single output register.
// A mid-line byte produces 2 or 3 characters; a line-closing byte up to 53.
// Reset (synchronous, active high) clears the offset, line position, state and output valid.
`default_nettype none

module hex_dump_line_formatter
  import hdlf_pkg::*;
#(
  parameter int BYTES_PER_LINE = BytesPerLineDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // end_of_data
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] text_char
  output logic            m_tlast    // last_of_run
);

  cmd_t cmd;
  sts_t sts;

  hdlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdlf_dp #(
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .in_eod    (s_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

  // Every byte yields several characters, so input stalls after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // A newline only closes a line and always ends its run
  a_nl_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == CH_NL) |-> m_tlast)
    else $error("newline without last mark");

  // Controller returns to idle after reset
  a_idle_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready)
    else $error("not ready after reset");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the hex dump line formatter.
`default_nettype none

module tb;
  import hdlf_pkg::*;

  localparam int BYTES_PER_LINE = 16;
  localparam int CLK_HALF       = 4;
  localparam int RANDOM_PER_PHASE = 86;
  localparam int PRESSURE_CYCLES  = 300;
  // A line-closing byte may produce up to 53 characters
  localparam int DRAIN_CYCLES   = 60;
  localparam int STALL_LIMIT    = 2000;
  localparam int REPORT_LIMIT   = 50;

  // One raw byte offered to the block
  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } dump_byte_t;

  // One character of dump text with its end-of-run flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       s_tlast = 1'b0;    // end_of_data
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] text_char
  logic       m_tlast;           // last_of_run

  // Predictor state: offset, fill of the current line and its ASCII column
  logic [31:0] line_ofs;
  logic [3:0]  line_pos;
  logic [7:0]  ascii_col [0:15];

  dump_byte_t byte_queue [$];
  text_beat_t expected_text [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  phase_no      = 0;
  int  hold_left     = 0;
  bit  pressure_done = 1'b0;
  bit  in_taken      = 1'b0;
  int  stall_cycles  = 0;
  int  fail_count    = 0;

  hex_dump_line_formatter #(
    .BYTES_PER_LINE(BYTES_PER_LINE)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Generate the clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Lower-case hex digit of one nibble
  function automatic logic [7:0] nibble_digit(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return "a" + {4'd0, nib} - 8'd10;
    end
    return "0" + {4'd0, nib};
  endfunction

  // Compute the characters one accepted byte produces and queue them
  task automatic format_byte(input logic [7:0] b, input logic eod);
    logic [7:0] run [$];
    int         fill;
    int         slot;
    int         k;
    if (line_pos == 4'd0) begin
      for (k = 0; k < 8; k++) begin
        run.push_back(nibble_digit(line_ofs[28 - 4 * k +: 4]));
      end
      run.push_back(CH_COLON);
      run.push_back(CH_SPACE);
    end
    run.push_back(nibble_digit(b[7:4]));
    run.push_back(nibble_digit(b[3:0]));
    if (line_pos[0]) begin
      run.push_back(CH_SPACE);
    end
    ascii_col[line_pos] = (b >= CH_LOW && b <= CH_HIGH) ? b : CH_DOT;
    fill = int'(line_pos) + 1;
    if (fill >= BYTES_PER_LINE || eod) begin
      // Pad missing slots so the byte grouping carries on
      for (slot = fill; slot < BYTES_PER_LINE; slot++) begin
        run.push_back(CH_SPACE);
        run.push_back(CH_SPACE);
        if (slot % 2 == 1) begin
          run.push_back(CH_SPACE);
        end
      end
      run.push_back(CH_SPACE);
      for (k = 0; k < fill; k++) begin
        run.push_back(ascii_col[k]);
      end
      run.push_back(CH_NL);
      line_ofs = line_ofs + BYTES_PER_LINE;
      line_pos = 4'd0;
    end else begin
      line_pos = fill[3:0];
    end
    for (k = 0; k < run.size(); k++) begin
      expected_text.push_back('{ch: run[k], last: (k == run.size() - 1)});
    end
  endtask

  task automatic add_byte(input logic [7:0] data, input logic eod);
    byte_queue.push_back('{data: data, eod: eod});
  endtask

  // Queue a random byte, leaning on printable values and the class boundaries
  task automatic add_random_byte();
    logic [7:0] data;
    logic [7:0] edges [6];
    edges = '{8'h00, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'hff};
    case ($urandom_range(3))
      1: data = 8'($urandom_range(8'h7e, 8'h20));
      2: data = edges[$urandom_range(5)];
      default: data = 8'($urandom);
    endcase
    add_byte(data, $urandom_range(11) == 0);
  endtask

  // Drive the byte stream; hold an item until it is transferred
  always @(negedge clk) begin
    dump_byte_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = byte_queue.pop_front();
        s_tdata  <= item.data;
        s_tlast  <= item.eod;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Drive the text-side ready, with one long hold-off in the last phase
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (phase_no == 2 && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = PRESSURE_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on each byte transfer, check each text transfer, watch for stalls
  always @(posedge clk) begin
    text_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        format_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $error("unexpected text_char %h with no character pending", m_tdata);
          end
        end else begin
          want = expected_text.pop_front();
          if (m_tdata !== want.ch) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $error("text_char: expected %h, actual %h", want.ch, m_tdata);
            end
          end
          if (m_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $error("last_of_run: expected %b, actual %b", want.last, m_tlast);
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Reset, then run three phases of stimulus with different idle patterns
  initial begin
    int ph;
    line_ofs = 32'd0;
    line_pos = 4'd0;
    for (ph = 0; ph < 16; ph++) begin
      ascii_col[ph] = 8'h00;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_no = ph;
      if (ph == 0) begin
        // End of data on the first byte of a line: longest padding
        add_byte(8'h00, 1'b1);
        // Full line across printable and non-printable boundaries
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h1f, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'h7e, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h7a, 1'b0);
        add_byte(8'h30, 1'b0);
        add_byte(8'h0a, 1'b0);
        add_byte(8'h09, 1'b0);
        add_byte(8'h5c, 1'b0);
        add_byte(8'h2e, 1'b0);
        add_byte(8'h60, 1'b0);
        add_byte(8'hc3, 1'b0);
        // Partial lines closed after an even and an odd byte count
        add_byte(8'h55, 1'b0);
        add_byte(8'haa, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h7e, 1'b1);
      end
      repeat (RANDOM_PER_PHASE) add_random_byte();
      while (byte_queue.size() != 0 || s_tvalid) @(posedge clk);
    end

    // Drain the remaining text, then allow for stray characters
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/hdlf_pkg.sv
hw/rtl/hdlf_ctrl.sv
hw/rtl/hdlf_dp.sv
hw/rtl/hex_dump_line_formatter.sv
tb/tb.sv
